// File: design/sdlm_pkg.sv
package sdlm_pkg;

  typedef enum logic [1:0] {
    FUNC_CHAR = 2'd0,
    FUNC_LEN  = 2'd1,
    FUNC_TEXT = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] word_index;
    logic [3:0] char_position;
    logic [7:0] char_value;
    logic [4:0] word_length;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [5:0] matched_word;
    logic [4:0] matched_length;
  } out_item_t;

endpackage

// File: design/sorted_dictionary_longest_match_unit.sv
// channel   | direction | handshake      | payload
// in        | input     | valid / stall  | in_item_t
// out       | output    | valid / stall  | out_item_t
// cfg       | input     | valid / ready  | word_count (7 bits)
// a load item is written without leaving idle; a text item runs two binary searches,
// each probe waiting for the registered read before its compare, plus the first-match
// check, a length read and a wrap-up. an item that is already decided skips the searches
// and does only the length read and the wrap-up.
// reset clears the run state and word_count; the memories are not cleared.
// the input is stalled while a text item is in work; the run's last item also waits
// in its last step while the output register still holds an item that is stalled.
module sorted_dictionary_longest_match_unit
  import sdlm_pkg::*;
#(
  parameter int MAX_WORDS    = 64,
  parameter int MAX_WORD_LEN = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [6:0] cfg_data_i
);

  localparam int WW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int PW = $clog2(MAX_WORD_LEN + 1);
  localparam int AW = $clog2(MAX_WORDS * MAX_WORD_LEN);
  localparam int CW = $clog2(MAX_WORD_LEN);

  typedef enum logic [3:0] {
    S_IDLE, S_LO_RD, S_LO_CHK, S_FIN_RD, S_FIN_CHK, S_HI_RD, S_HI_CHK, S_LEN, S_DONE
  } state_e;

  logic [7:0] chars_mem [MAX_WORDS*MAX_WORD_LEN];
  logic [4:0] lens_mem  [MAX_WORDS];

  state_e     state_q;
  logic [6:0] word_count_q;
  logic [WW-1:0] rlow_q, rhigh_q, best_q;
  logic [PW-1:0] pos_q;
  logic       best_valid_q, decided_q;
  logic [WW:0] a_q, b_q, m_q;
  logic [8:0] t_q;
  logic       last_q;
  logic       len_hit_q;
  logic       out_valid_q;
  out_item_t  out_q;

  // one read port each, data registered
  logic [WW-1:0] rd_w;
  logic [CW-1:0] rd_p;
  logic [7:0] rd_char_q;
  logic [4:0] rd_len_q;

  wire in_acc   = in_valid_i && !in_stall_o;
  wire out_load = (state_q == S_DONE) && last_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && func_e'(in_item_i.func) == FUNC_CHAR &&
        32'(in_item_i.word_index) < MAX_WORDS &&
        32'(in_item_i.char_position) < MAX_WORD_LEN)
      chars_mem[AW'(32'(in_item_i.word_index) * MAX_WORD_LEN +
                    32'(in_item_i.char_position))] <= in_item_i.char_value;
    if (in_acc && func_e'(in_item_i.func) == FUNC_LEN &&
        32'(in_item_i.word_index) < MAX_WORDS)
      lens_mem[WW'(in_item_i.word_index)] <= in_item_i.word_length;
    rd_char_q  <= chars_mem[AW'(32'(rd_w) * MAX_WORD_LEN + 32'(rd_p))];
    rd_len_q   <= lens_mem[rd_w];
  end

  // key of the word read last cycle at pos_q: 0 terminator else char+1
  logic [8:0] key;
  assign key = (32'(pos_q) < 32'(rd_len_q)) ? {1'b0, rd_char_q} + 9'd1 : 9'd0;

  // pos_q < MAX_WORD_LEN while searching
  assign rd_p = pos_q[CW-1:0];

  logic [WW:0] mid_lo, mid_hi;
  assign mid_lo = (a_q + b_q) >> 1;
  assign mid_hi = (a_q + b_q + 1'b1) >> 1;

  always_comb begin
    case (state_q)
      S_LO_RD:  rd_w = mid_lo[WW-1:0];
      S_FIN_RD: rd_w = a_q[WW-1:0];
      S_HI_RD:  rd_w = mid_hi[WW-1:0];
      S_LEN:    rd_w = best_q;
      S_DONE:   rd_w = best_q;
      default:  rd_w = rlow_q;
    endcase
  end

  logic [6:0] n_eff;
  assign n_eff = (32'(word_count_q) > MAX_WORDS) ? 7'(MAX_WORDS) : word_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      word_count_q <= '0;
      rlow_q <= '0; rhigh_q <= '0; best_q <= '0; pos_q <= '0;
      best_valid_q <= 1'b0; decided_q <= 1'b0;
      a_q <= '0; b_q <= '0; m_q <= '0; t_q <= '0; last_q <= 1'b0;
      len_hit_q <= 1'b0;
      out_valid_q <= 1'b0; out_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) word_count_q <= cfg_data_i;
      if (out_load) begin
        out_valid_q          <= 1'b1;
        out_q.found          <= best_valid_q;
        out_q.matched_word   <= best_valid_q ? 6'(best_q) : 6'd0;
        out_q.matched_length <= best_valid_q ? rd_len_q : 5'd0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && func_e'(in_item_i.func) == FUNC_TEXT) begin
            t_q    <= {1'b0, in_item_i.char_value} + 9'd1;
            last_q <= in_item_i.text_last;
            if (!decided_q && pos_q == '0 && n_eff == '0) begin
              // empty dictionary decides the run
              decided_q <= 1'b1;
              state_q   <= S_LEN;
            end else if (decided_q || 32'(pos_q) >= MAX_WORD_LEN) begin
              decided_q <= 1'b1;
              state_q   <= S_LEN;
            end else if (pos_q == '0) begin
              rlow_q  <= '0;
              rhigh_q <= WW'(n_eff - 7'd1);
              a_q     <= '0;
              b_q     <= (WW+1)'(n_eff);
              state_q <= S_LO_RD;
            end else begin
              a_q     <= {1'b0, rlow_q};
              b_q     <= {1'b0, rhigh_q} + 1'b1;
              state_q <= S_LO_RD;
            end
          end
        end
        S_LO_RD: begin
          if (a_q < b_q) begin
            m_q <= mid_lo;
            state_q <= S_LO_CHK;
          end else if (a_q > {1'b0, rhigh_q}) begin
            decided_q <= 1'b1;
            state_q <= S_LEN;
          end else state_q <= S_FIN_RD;
        end
        S_LO_CHK: begin
          if (key < t_q) a_q <= m_q + 1'b1;
          else b_q <= m_q;
          state_q <= S_LO_RD;
        end
        S_FIN_RD: state_q <= S_FIN_CHK;
        S_FIN_CHK: begin
          if (key != t_q) begin
            decided_q <= 1'b1;
            state_q <= S_LEN;
          end else begin
            // the read of the first candidate also brought its length
            rlow_q <= a_q[WW-1:0];
            len_hit_q <= (32'(rd_len_q) == 32'(pos_q) + 32'd1);
            b_q <= {1'b0, rhigh_q};
            state_q <= S_HI_RD;
          end
        end
        S_HI_RD: begin
          if (a_q < b_q) begin
            m_q <= mid_hi;
            state_q <= S_HI_CHK;
          end else begin
            rhigh_q <= a_q[WW-1:0];
            if (len_hit_q) begin
              best_q <= rlow_q;
              best_valid_q <= 1'b1;
              if (rlow_q == a_q[WW-1:0]) decided_q <= 1'b1;
              else rlow_q <= rlow_q + 1'b1;
            end
            state_q <= S_LEN;
          end
        end
        S_HI_CHK: begin
          if (key > t_q) b_q <= m_q - 1'b1;
          else a_q <= m_q;
          state_q <= S_HI_RD;
        end
        S_LEN: begin
          // length of the best word is read here for the result
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!last_q) begin
            if (32'(pos_q) < MAX_WORD_LEN) pos_q <= pos_q + 1'b1;
            state_q <= S_IDLE;
          end else if (out_load) begin
            rlow_q <= '0; rhigh_q <= '0; pos_q <= '0; best_q <= '0;
            best_valid_q <= 1'b0; decided_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/sorted_dictionary_longest_match_unit_tb.sv
`timescale 1ns / 1ps

module sorted_dictionary_longest_match_unit_tb;
  import sdlm_pkg::*;

  localparam int NWORDS    = 64;
  localparam int WLEN      = 16;
  localparam int LIMIT     = 600000;
  localparam int ITEM_GOAL = 1150;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [6:0] cfg_data_i = '0;

  sorted_dictionary_longest_match_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0] mem_chars [NWORDS*WLEN];
  logic [4:0] mem_lens [NWORDS];
  int unsigned words_in_use;
  int unsigned lo_word, hi_word, text_pos, best_idx;
  bit best_ok, settled;
  out_item_t match_q[$];

  int errors = 0;
  int items_sent = 0;
  int unsigned cycles = 0;
  bit quiet_in = 0;
  bit quiet_out = 0;

  // dictionary image being built for loading
  byte unsigned dw_chars [NWORDS][WLEN];
  int dw_len [NWORDS];

  function automatic int unsigned sort_key(int unsigned w, int unsigned p);
    if (w >= NWORDS || p >= WLEN) return 0;
    if (p < mem_lens[w]) return mem_chars[w*WLEN+p] + 1;
    return 0;
  endfunction

  function automatic void clear_search();
    lo_word = 0; hi_word = 0; text_pos = 0; best_idx = 0; best_ok = 0; settled = 0;
  endfunction

  function automatic void scan_text_char(int unsigned c);
    int unsigned p, t, a, b, m, n;
    p = text_pos;
    t = c + 1;
    if (!settled && p == 0) begin
      n = (words_in_use > NWORDS) ? NWORDS : words_in_use;
      if (n == 0) settled = 1;
      else begin
        lo_word = 0;
        hi_word = n - 1;
      end
    end
    if (!settled && p >= WLEN) settled = 1;
    if (!settled) begin
      a = lo_word;
      b = hi_word + 1;
      while (a < b) begin
        m = (a + b) / 2;
        if (sort_key(m, p) < t) a = m + 1;
        else b = m;
      end
      if (a > hi_word || sort_key(a, p) != t) settled = 1;
      else begin
        lo_word = a;
        b = hi_word;
        while (a < b) begin
          m = (a + b + 1) / 2;
          if (sort_key(m, p) > t) b = m - 1;
          else a = m;
        end
        hi_word = a;
        if (mem_lens[lo_word] == p + 1) begin
          best_idx = lo_word;
          best_ok = 1;
          if (lo_word == hi_word) settled = 1;
          else lo_word++;
        end
      end
    end
    if (text_pos < WLEN) text_pos++;
  endfunction

  function automatic void predict_item(in_item_t it);
    out_item_t r;
    case (func_e'(it.func))
      FUNC_CHAR: mem_chars[it.word_index*WLEN + it.char_position] = it.char_value;
      FUNC_LEN:  mem_lens[it.word_index] = it.word_length;
      FUNC_TEXT: begin
        scan_text_char(it.char_value);
        if (it.text_last) begin
          r = '0;
          if (best_ok) begin
            r.found = 1'b1;
            r.matched_word = best_idx[5:0];
            r.matched_length = mem_lens[best_idx];
          end
          match_q = {match_q, r};
          clear_search();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(in_item_t it);
    int g;
    g = pick_gap(quiet_in);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(it);
    items_sent++;
  endtask

  function automatic in_item_t make_item(func_e f, int widx, int cpos, int cval, int wlen,
                                         bit last);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'($urandom));
    it.func = f;
    if (f != FUNC_TEXT) it.text_last = 1'($urandom_range(0, 1));
    else it.text_last = last;
    if (f == FUNC_CHAR || f == FUNC_LEN) it.word_index = 6'(widx);
    if (f == FUNC_CHAR) it.char_position = 4'(cpos);
    if (f == FUNC_CHAR || f == FUNC_TEXT) it.char_value = 8'(cval);
    if (f == FUNC_LEN) it.word_length = 5'(wlen);
    return it;
  endfunction

  task automatic send_text(byte unsigned txt[$]);
    foreach (txt[i]) send_item(make_item(FUNC_TEXT, 0, 0, txt[i], 0, i == txt.size() - 1));
  endtask

  task automatic load_dict(int n);
    int k;
    for (int w = 0; w < n; w++) begin
      k = (dw_len[w] > WLEN) ? WLEN : dw_len[w];
      for (int p = 0; p < k; p++) begin
        send_item(make_item(FUNC_CHAR, w, p, dw_chars[w][p], 0, 0));
        if ($urandom_range(0, 40) == 0) send_item(make_item(FUNC_NONE, 0, 0, 0, 0, 0));
      end
      send_item(make_item(FUNC_LEN, w, 0, 0, dw_len[w], 0));
    end
  endtask

  // word count changes only once the block has drained
  task automatic set_word_count(int v);
    in_valid_i <= 1'b0;
    while (match_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v[6:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    words_in_use = v;
  endtask

  function automatic int cmp_words(int x, int y);
    int kx, ky;
    for (int p = 0; p < WLEN; p++) begin
      kx = (p < dw_len[x]) ? dw_chars[x][p] + 1 : 0;
      ky = (p < dw_len[y]) ? dw_chars[y][p] + 1 : 0;
      if (kx != ky) return (kx < ky) ? -1 : 1;
    end
    return 0;
  endfunction

  function automatic byte unsigned rand_char(bit wide);
    if (wide) return 8'($urandom_range(0, 255));
    return 8'(8'h61 + $urandom_range(0, 3));
  endfunction

  function automatic void build_dict(int n, bit wide);
    int r, tmp, dup;
    byte unsigned c;
    for (int w = 0; w < n; w++) begin
      do begin
        r = $urandom_range(0, 99);
        if (r < 3) dw_len[w] = 0;
        else if (r < 8) dw_len[w] = $urandom_range(16, 31);
        else dw_len[w] = $urandom_range(1, 6);
        for (int p = 0; p < WLEN; p++) dw_chars[w][p] = rand_char(wide);
        dup = 0;
        for (int v = 0; v < w; v++) if (cmp_words(v, w) == 0) dup = 1;
      end while (dup);
    end
    if ($urandom_range(0, 9) != 0) begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j + 1 < n - i; j++)
          if (cmp_words(j, j + 1) > 0) begin
            tmp = dw_len[j]; dw_len[j] = dw_len[j+1]; dw_len[j+1] = tmp;
            for (int p = 0; p < WLEN; p++) begin
              c = dw_chars[j][p]; dw_chars[j][p] = dw_chars[j+1][p]; dw_chars[j+1][p] = c;
            end
          end
    end
  endfunction

  task automatic test_empty_dictionary();
    byte unsigned t[$];
    t = '{8'h61, 8'h00, 8'hFF};
    send_text(t);
    t = '{8'h62};
    send_text(t);
  endtask

  task automatic test_directed_dictionary();
    byte unsigned t[$];
    // zero-length word, NUL word, "a", "ab", "abc", long word of 0xff that never ends
    dw_len[0] = 0;
    dw_len[1] = 1; dw_chars[1][0] = 8'h00;
    dw_len[2] = 1; dw_chars[2][0] = 8'h61;
    dw_len[3] = 2; dw_chars[3][0] = 8'h61; dw_chars[3][1] = 8'h62;
    dw_len[4] = 3; dw_chars[4][0] = 8'h61; dw_chars[4][1] = 8'h62; dw_chars[4][2] = 8'h63;
    dw_len[5] = 17;
    for (int p = 0; p < WLEN; p++) dw_chars[5][p] = 8'hFF;
    load_dict(6);
    set_word_count(6);
    t = '{8'h61, 8'h62, 8'h63, 8'h78};
    send_text(t);
    t = '{8'h61, 8'h62};
    send_text(t);
    t = '{8'h00};
    send_text(t);
    t = '{8'h7A};
    send_text(t);
    t = {};
    for (int i = 0; i < 20; i++) t = {t, 8'hFF};
    send_text(t);
    // loads and an ignored item in the middle of a run
    send_item(make_item(FUNC_TEXT, 0, 0, 8'h61, 0, 0));
    send_item(make_item(FUNC_CHAR, 63, 15, 8'h55, 0, 0));
    send_item(make_item(FUNC_LEN, 62, 0, 0, 31, 0));
    send_item(make_item(FUNC_NONE, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_TEXT, 0, 0, 8'h62, 0, 1));
  endtask

  task automatic test_random_runs();
    int n, runs, w, k, tl;
    bit wide;
    byte unsigned t[$];
    while (items_sent < ITEM_GOAL) begin
      quiet_in = ($urandom_range(0, 4) == 0);
      wide = ($urandom_range(0, 5) == 0);
      n = ($urandom_range(0, 7) == 0) ? NWORDS : $urandom_range(1, 12);
      build_dict(n, wide);
      load_dict(n);
      if (n == NWORDS && $urandom_range(0, 1)) set_word_count($urandom_range(NWORDS, 127));
      else if ($urandom_range(0, 5) == 0) set_word_count($urandom_range(0, n));
      else set_word_count(n);
      runs = $urandom_range(4, 10);
      for (int r = 0; r < runs; r++) begin
        t = {};
        tl = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
        if ($urandom_range(0, 4) != 0) begin
          w = $urandom_range(0, n - 1);
          k = (dw_len[w] > WLEN) ? WLEN : dw_len[w];
          for (int p = 0; p < k && p < tl; p++) t = {t, dw_chars[w][p]};
        end
        while (t.size() < tl) t = {t, rand_char(wide || $urandom_range(0, 9) == 0)};
        send_text(t);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (quiet_out) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 99) < 25) out_stall_i <= 1'b1;
    else if ($urandom_range(0, 99) < 70) out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 2000) == 0) quiet_out <= ~quiet_out;
  end

  always @(posedge clk_i) begin
    out_item_t exp_r;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (match_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_item_o);
        errors++;
      end else begin
        exp_r = match_q.pop_front();
        if (out_item_o.found !== exp_r.found) begin
          $display("%0t found exp %0d got %0d", $time, exp_r.found, out_item_o.found);
          errors++;
        end
        if (out_item_o.matched_word !== exp_r.matched_word) begin
          $display("%0t matched_word exp %0d got %0d", $time, exp_r.matched_word,
                   out_item_o.matched_word);
          errors++;
        end
        if (out_item_o.matched_length !== exp_r.matched_length) begin
          $display("%0t matched_length exp %0d got %0d", $time, exp_r.matched_length,
                   out_item_o.matched_length);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NWORDS*WLEN; i++) mem_chars[i] = '0;
    for (int i = 0; i < NWORDS; i++) mem_lens[i] = '0;
    words_in_use = 0;
    clear_search();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_dictionary();
    test_directed_dictionary();
    test_random_runs();
    while (match_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
